// ===== rtl/aip_pkg.sv =====
// shared constants and letter classification functions for the pair identity block
package aip_pkg;

  localparam logic [7:0] DASH_CHAR  = 8'h2D;
  localparam logic [7:0] DOT_CHAR   = 8'h2E;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] LOWER_A    = 8'h61;
  localparam logic [7:0] LOWER_Z    = 8'h7A;
  localparam logic [7:0] CASE_DIFF  = 8'h20;

  localparam int TOTAL_W = 16;
  localparam int QUOT_W  = 17;
  localparam int STEP_W  = $clog2(QUOT_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUOT_W - 1);

  function automatic logic is_lower(input logic [7:0] ch);
    is_lower = (ch >= LOWER_A) && (ch <= LOWER_Z);
  endfunction

  function automatic logic [7:0] fold_upper(input logic [7:0] ch);
    fold_upper = is_lower(ch) ? ch - CASE_DIFF : ch;
  endfunction

  function automatic logic is_dash_dot(input logic [7:0] ch);
    is_dash_dot = (ch == DASH_CHAR) || (ch == DOT_CHAR);
  endfunction

  function automatic logic is_gap(input logic [7:0] ch);
    is_gap = is_dash_dot(ch) || (ch == SPACE_CHAR);
  endfunction

endpackage

// ===== rtl/aip_front.sv =====
// front end: classifies letter pairs and keeps the saturating running counts
module aip_front import aip_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [7:0]              letter_a_i,
  input  logic [7:0]              letter_b_i,
  input  logic                    last_i,
  output logic                    rec_push_o,
  output logic [4*COUNT_BITS-1:0] rec_data_o
);

  localparam logic [COUNT_BITS-1:0] CountMax = '1;
  localparam logic [COUNT_BITS-1:0] CountOne = COUNT_BITS'(1);

  logic [COUNT_BITS-1:0] match_q, match_d;
  logic [COUNT_BITS-1:0] cmp_q, cmp_d;
  logic [COUNT_BITS-1:0] aln_q, aln_d;
  logic [COUNT_BITS-1:0] cap_q, cap_d;
  logic [COUNT_BITS-1:0] match_n, cmp_n, aln_n, cap_n;
  logic compared, aligned, capital, equal;

  always_comb begin
    compared = !is_dash_dot(letter_a_i) && !is_dash_dot(letter_b_i);
    aligned  = !is_gap(letter_a_i) && !is_gap(letter_b_i);
    capital  = !is_lower(letter_a_i) && !is_lower(letter_b_i);
    equal    = fold_upper(letter_a_i) == fold_upper(letter_b_i);

    match_n = match_q;
    cmp_n   = cmp_q;
    aln_n   = aln_q;
    cap_n   = cap_q;
    if (compared) begin
      if (equal && cmp_q != CountMax) begin
        match_n = match_q + CountOne;
      end
      if (cmp_q != CountMax) begin
        cmp_n = cmp_q + CountOne;
      end
    end
    if (aligned) begin
      if (aln_q != CountMax) begin
        aln_n = aln_q + CountOne;
      end
      if (capital && cap_q != CountMax) begin
        cap_n = cap_q + CountOne;
      end
    end

    match_d = match_q;
    cmp_d   = cmp_q;
    aln_d   = aln_q;
    cap_d   = cap_q;
    if (accept_i) begin
      if (last_i) begin
        match_d = '0;
        cmp_d   = '0;
        aln_d   = '0;
        cap_d   = '0;
      end else begin
        match_d = match_n;
        cmp_d   = cmp_n;
        aln_d   = aln_n;
        cap_d   = cap_n;
      end
    end
  end

  assign rec_push_o = accept_i && last_i;
  assign rec_data_o = {match_n, cmp_n, aln_n, cap_n};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '0;
      cmp_q   <= '0;
      aln_q   <= '0;
      cap_q   <= '0;
    end else begin
      match_q <= match_d;
      cmp_q   <= cmp_d;
      aln_q   <= aln_d;
      cap_q   <= cap_d;
    end
  end

endmodule

// ===== rtl/aip_queue.sv =====
// two-entry queue of finished count records between front and back
module aip_queue import aip_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic [1:0]       cnt_q, cnt_d;
  logic             wr_q, rd_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= !wr_q;
      end
      if (do_pop) begin
        rd_q <= !rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/aip_back.sv =====
// back end: bit-serial identity divider and result register
module aip_back import aip_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    rec_valid_i,
  input  logic [4*COUNT_BITS-1:0] rec_data_i,
  output logic                    rec_pop_o,
  output logic                    empty_o,
  input  logic                    pop_i,
  output logic [TOTAL_W-1:0]      match_total_o,
  output logic [TOTAL_W-1:0]      compared_total_o,
  output logic [TOTAL_W-1:0]      aligned_total_o,
  output logic [TOTAL_W-1:0]      cap_aligned_total_o,
  output logic [QUOT_W-1:0]       identity_q16_o
);

  localparam int ExtW = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [COUNT_BITS-1:0] match_q, cmp_q, aln_q, cap_q;
  logic [COUNT_BITS:0]   rem_q, rem_d;
  logic [QUOT_W-1:0]     quot_q, quot_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [COUNT_BITS:0]   divisor, trial, rem_keep;
  logic                  ge, load;
  logic [COUNT_BITS-1:0] r_match, r_cmp, r_aln, r_cap;
  logic [ExtW-1:0]       ext_match, ext_cmp, ext_aln, ext_cap;

  assign {r_match, r_cmp, r_aln, r_cap} = rec_data_i;
  assign load      = (state_q == S_IDLE) && rec_valid_i;
  assign rec_pop_o = load;
  assign divisor   = {1'b0, cmp_q};
  assign trial     = rem_q - divisor;
  assign ge        = rem_q >= divisor;
  assign rem_keep  = ge ? trial : rem_q;

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    step_d  = step_q;
    case (state_q)
      S_IDLE: begin
        if (rec_valid_i) begin
          rem_d  = {1'b0, r_match};
          quot_d = '0;
          step_d = LAST_STEP;
          state_d = (r_cmp == '0) ? S_DONE : S_DIV;
        end
      end
      S_DIV: begin
        quot_d = {quot_q[QUOT_W-2:0], ge};
        rem_d  = {rem_keep[COUNT_BITS-1:0], 1'b0};
        if (step_q == '0) begin
          state_d = S_DONE;
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
      S_DONE: begin
        if (pop_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    step_q <= step_d;
    if (load) begin
      match_q <= r_match;
      cmp_q   <= r_cmp;
      aln_q   <= r_aln;
      cap_q   <= r_cap;
    end
  end

  assign ext_match = ExtW'(match_q);
  assign ext_cmp   = ExtW'(cmp_q);
  assign ext_aln   = ExtW'(aln_q);
  assign ext_cap   = ExtW'(cap_q);

  assign empty_o             = state_q != S_DONE;
  assign match_total_o       = ext_match[TOTAL_W-1:0];
  assign compared_total_o    = ext_cmp[TOTAL_W-1:0];
  assign aligned_total_o     = ext_aln[TOTAL_W-1:0];
  assign cap_aligned_total_o = ext_cap[TOTAL_W-1:0];
  assign identity_q16_o      = quot_q;

  // identity never exceeds one
  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (quot_q <= (QUOT_W'(1) << (QUOT_W - 1))))
    else $error("identity above one");

  // nothing compared gives zero identity
  a_zero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && cmp_q == '0) |-> (quot_q == '0))
    else $error("nonzero identity with nothing compared");

  // partial remainder stays below twice the divisor during each step
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < (divisor << 1)))
    else $error("remainder out of range");

  // result is held until its transfer
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !pop_i) |=> (state_q == S_DONE && $stable(quot_q)))
    else $error("result dropped before transfer");

endmodule

// ===== rtl/aligned_pair_identity.sv =====
// top level of the aligned pair identity counter
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------------------
//   pairs in | push / full        | letter_a_i, letter_b_i, last_i
//   results  | empty / pop        | match_total_o, compared_total_o,
//            |                    | aligned_total_o, cap_aligned_total_o,
//            |                    | identity_q16_o
//
// one letter pair is taken every cycle while full is low; only a pair with last set makes a result
// a result is ready once the one-bit-a-cycle divider has made all 17 quotient bits
// a result with nothing compared skips the divider and goes straight from idle to done
// up to two finished count records wait between the counters and the divider
// full rises only while both records are waiting; reset clears counts and queues
module aligned_pair_identity import aip_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         letter_a_i,
  input  logic [7:0]         letter_b_i,
  input  logic               last_i,
  output logic               empty,
  input  logic               pop,
  output logic [TOTAL_W-1:0] match_total_o,
  output logic [TOTAL_W-1:0] compared_total_o,
  output logic [TOTAL_W-1:0] aligned_total_o,
  output logic [TOTAL_W-1:0] cap_aligned_total_o,
  output logic [QUOT_W-1:0]  identity_q16_o
);

  localparam int RecW = 4 * COUNT_BITS;

  logic            accept;
  logic            rec_push, rec_valid, rec_pop;
  logic [RecW-1:0] rec_in, rec_out;

  assign accept = push && !full;

  aip_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .letter_a_i (letter_a_i),
    .letter_b_i (letter_b_i),
    .last_i     (last_i),
    .rec_push_o (rec_push),
    .rec_data_o (rec_in)
  );

  aip_queue #(.WIDTH(RecW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .data_i  (rec_in),
    .full_o  (full),
    .pop_i   (rec_pop),
    .valid_o (rec_valid),
    .data_o  (rec_out)
  );

  aip_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .rec_valid_i         (rec_valid),
    .rec_data_i          (rec_out),
    .rec_pop_o           (rec_pop),
    .empty_o             (empty),
    .pop_i               (pop),
    .match_total_o       (match_total_o),
    .compared_total_o    (compared_total_o),
    .aligned_total_o     (aligned_total_o),
    .cap_aligned_total_o (cap_aligned_total_o),
    .identity_q16_o      (identity_q16_o)
  );

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the aligned pair identity counter
module tb_top;
  import aip_pkg::*;

  typedef struct packed {
    logic [TOTAL_W-1:0] match_tot;
    logic [TOTAL_W-1:0] compared;
    logic [TOTAL_W-1:0] aligned;
    logic [TOTAL_W-1:0] cap_aligned;
    logic [QUOT_W-1:0]  identity;
  } identity_report_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_e;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int UNIFORM_RUN  = 30;
  localparam logic [TOTAL_W-1:0] COUNT_TOP = '1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic [7:0] letter_a_i = 8'h00;
  logic [7:0] letter_b_i = 8'h00;
  logic last_i = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  logic [TOTAL_W-1:0] match_total_o;
  logic [TOTAL_W-1:0] compared_total_o;
  logic [TOTAL_W-1:0] aligned_total_o;
  logic [TOTAL_W-1:0] cap_aligned_total_o;
  logic [QUOT_W-1:0]  identity_q16_o;

  identity_report_t pending_reports[$];
  logic [TOTAL_W-1:0] match_cnt = '0;
  logic [TOTAL_W-1:0] compared_cnt = '0;
  logic [TOTAL_W-1:0] aligned_cnt = '0;
  logic [TOTAL_W-1:0] cap_cnt = '0;

  int fail_count = 0;
  int cycle_count = 0;
  int sender_max_gap = 0;
  int burst_left = 0;
  rx_mode_e rx_mode = RX_ALWAYS;
  int hold_orders = 0;
  int hold_served = 0;
  int hold_left = 0;
  int pattern_pos = 0;

  aligned_pair_identity dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .letter_a_i         (letter_a_i),
    .letter_b_i         (letter_b_i),
    .last_i             (last_i),
    .empty              (empty),
    .pop                (pop),
    .match_total_o      (match_total_o),
    .compared_total_o   (compared_total_o),
    .aligned_total_o    (aligned_total_o),
    .cap_aligned_total_o(cap_aligned_total_o),
    .identity_q16_o     (identity_q16_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("aligned_pair_identity: mismatch");
      $finish;
    end
  end

  // running counts for one transfer, report on last
  task automatic tally_pair(input logic [7:0] a, input logic [7:0] b, input logic is_last);
    logic a_dd, b_dd, a_low, b_low;
    logic [7:0] a_up, b_up;
    identity_report_t rep;
    logic [47:0] scaled;
    a_dd = (a == DASH_CHAR) || (a == DOT_CHAR);
    b_dd = (b == DASH_CHAR) || (b == DOT_CHAR);
    a_low = (a >= LOWER_A) && (a <= LOWER_Z);
    b_low = (b >= LOWER_A) && (b <= LOWER_Z);
    a_up = a_low ? a - CASE_DIFF : a;
    b_up = b_low ? b - CASE_DIFF : b;
    if (!a_dd && !b_dd) begin
      if (a_up == b_up && compared_cnt != COUNT_TOP && match_cnt != COUNT_TOP)
        match_cnt++;
      if (compared_cnt != COUNT_TOP)
        compared_cnt++;
    end
    if (!a_dd && !b_dd && a != SPACE_CHAR && b != SPACE_CHAR) begin
      if (aligned_cnt != COUNT_TOP)
        aligned_cnt++;
      if (!a_low && !b_low && cap_cnt != COUNT_TOP)
        cap_cnt++;
    end
    if (is_last) begin
      rep.match_tot = match_cnt;
      rep.compared = compared_cnt;
      rep.aligned = aligned_cnt;
      rep.cap_aligned = cap_cnt;
      if (compared_cnt == '0) begin
        rep.identity = '0;
      end else begin
        scaled = {16'h0000, match_cnt, 16'h0000} / {32'h0, compared_cnt};
        rep.identity = scaled[QUOT_W-1:0];
      end
      pending_reports.push_back(rep);
      match_cnt = '0;
      compared_cnt = '0;
      aligned_cnt = '0;
      cap_cnt = '0;
    end
  endtask

  task automatic send_pair(input logic [7:0] a, input logic [7:0] b, input logic is_last);
    int gap;
    push <= 1'b1;
    letter_a_i <= a;
    letter_b_i <= b;
    last_i <= is_last;
    do @(posedge clk_i); while (full);
    tally_pair(a, b, is_last);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = (sender_max_gap == 0) ? 0 : $urandom_range(0, sender_max_gap);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(0, 9))
      0: pick_letter = DASH_CHAR;
      1: pick_letter = DOT_CHAR;
      2: pick_letter = SPACE_CHAR;
      3, 4: pick_letter = 8'($urandom_range(8'h61, 8'h7A));
      5, 6, 7: pick_letter = 8'($urandom_range(8'h41, 8'h5A));
      default: pick_letter = 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_partner(input logic [7:0] a);
    logic [7:0] b;
    b = pick_letter();
    if ($urandom_range(0, 9) < 5) begin
      b = a;
      if (((a >= 8'h41 && a <= 8'h5A) || (a >= LOWER_A && a <= LOWER_Z))
          && $urandom_range(0, 1) == 1)
        b = a ^ CASE_DIFF;
    end
    pick_partner = b;
  endfunction

  // result side: check accepted transfer, then choose pop for next cycle
  always @(posedge clk_i) begin
    identity_report_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result transfer");
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (match_total_o !== want.match_tot) begin
          $error("match_total exp %0d got %0d", want.match_tot, match_total_o);
          fail_count++;
        end
        if (compared_total_o !== want.compared) begin
          $error("compared_total exp %0d got %0d", want.compared, compared_total_o);
          fail_count++;
        end
        if (aligned_total_o !== want.aligned) begin
          $error("aligned_total exp %0d got %0d", want.aligned, aligned_total_o);
          fail_count++;
        end
        if (cap_aligned_total_o !== want.cap_aligned) begin
          $error("cap_aligned_total exp %0d got %0d", want.cap_aligned, cap_aligned_total_o);
          fail_count++;
        end
        if (identity_q16_o !== want.identity) begin
          $error("identity_q16 exp %0d got %0d", want.identity, identity_q16_o);
          fail_count++;
        end
      end
    end
    if (hold_served != hold_orders) begin
      hold_served = hold_orders;
      hold_left = HOLD_CYCLES;
    end
    pattern_pos = (pattern_pos + 1) % 7;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: pop <= 1'b1;
        RX_RANDOM: pop <= 1'($urandom_range(0, 1));
        RX_PATTERN: pop <= (pattern_pos < 3);
        default: pop <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  task automatic test_directed();
    sender_max_gap = 2;
    rx_mode = RX_RANDOM;
    send_pair("A", "a", 1'b0);
    send_pair("z", "Z", 1'b0);
    send_pair("-", "A", 1'b0);
    send_pair(".", ".", 1'b0);
    send_pair(" ", "B", 1'b0);
    send_pair("B", " ", 1'b0);
    send_pair(8'hFF, 8'hFF, 1'b0);
    send_pair(8'h80, 8'h7F, 1'b0);
    send_pair("a", "b", 1'b0);
    send_pair(8'h60, "@", 1'b0);
    send_pair("{", "[", 1'b0);
    send_pair(8'h00, 8'h00, 1'b1);
    send_pair("-", ".", 1'b1);
    send_pair(" ", " ", 1'b1);
    send_pair("A", "C", 1'b1);
    send_pair("A", "A", 1'b0);
    send_pair("A", "B", 1'b0);
    send_pair("c", "d", 1'b1);
    send_pair(8'hFF, 8'h00, 1'b1);
    wait_drained();
  endtask

  task automatic test_uniform_runs();
    sender_max_gap = 0;
    rx_mode = RX_ALWAYS;
    repeat (5) send_pair("A", "B", 1'b0);
    for (int i = 0; i < UNIFORM_RUN; i++)
      send_pair("A", "A", i == UNIFORM_RUN - 1);
    for (int i = 0; i < UNIFORM_RUN; i++)
      send_pair("G", i[0] ? "g" : "G", i == UNIFORM_RUN - 1);
    wait_drained();
  endtask

  task automatic test_random_stream();
    int sent;
    int len;
    int phase;
    logic [7:0] a;
    sent = 0;
    phase = 0;
    while (sent < 1500) begin
      if (sent >= phase * 300) begin
        wait_drained();
        rx_mode = rx_mode_e'(phase % 4);
        sender_max_gap = (phase % 3 == 1) ? 0 : $urandom_range(1, 8);
        phase++;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 150) : $urandom_range(1, 24);
      for (int i = 0; i < len; i++) begin
        a = pick_letter();
        send_pair(a, pick_partner(a), i == len - 1);
      end
      sent += len;
    end
    wait_drained();
  endtask

  task automatic test_result_backlog();
    logic [7:0] a;
    sender_max_gap = 0;
    rx_mode = RX_ALWAYS;
    hold_orders++;
    repeat (60) begin
      a = pick_letter();
      send_pair(a, pick_partner(a), $urandom_range(0, 3) != 0);
    end
    a = pick_letter();
    send_pair(a, pick_partner(a), 1'b1);
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_result_backlog();
    test_uniform_runs();
    test_random_stream();
    test_result_backlog();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("aligned_pair_identity: match");
    end else begin
      $display("aligned_pair_identity: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/aip_pkg.sv
rtl/aip_front.sv
rtl/aip_queue.sv
rtl/aip_back.sv
rtl/aligned_pair_identity.sv
dv/tb_top.sv
